// File: rtl/three_phase_pwm_duty_generator_defines.svh
// assertion helpers, clocked on aclk and held off during reset
`ifndef THREE_PHASE_PWM_DUTY_GENERATOR_DEFINES_SVH
`define THREE_PHASE_PWM_DUTY_GENERATOR_DEFINES_SVH

`define TPWM_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("tpwm check failed");

`define TPWM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("tpwm check failed");

`endif

// File: rtl/tpwm_pkg.sv
package tpwm_pkg;
    localparam int QUO_W = 31;
    localparam int DIV_W = 16;
    localparam int LANES = 3;
    localparam int ANGLES = 6;
    localparam logic [15:0] THIRD_TURN = 16'd21845;
    localparam logic [15:0] QUARTER_TURN = 16'd16384;
    typedef logic signed [15:0] q15_t;
endpackage

// File: rtl/tpwm_sincos.sv
module tpwm_sincos #(
    parameter int SINE_TABLE_ENTRIES = 256
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               valid_in,
    input  logic [15:0]        angle,
    output logic               valid_out,
    output tpwm_pkg::q15_t     sin_out [3],
    output tpwm_pkg::q15_t     cos_out [3]
);
    import tpwm_pkg::*;

    localparam int IDX_W = $clog2(SINE_TABLE_ENTRIES);
    localparam int PW = 16 + IDX_W;
    localparam longint unsigned HALF_PI_Q28 = 64'd421657428;

    function automatic logic signed [15:0] table_entry(input int k);
        longint unsigned u, quad, rem, part, x, x2, term;
        longint sum, s;
        u = longint'(k) * 4;
        quad = u / SINE_TABLE_ENTRIES;
        rem = u % SINE_TABLE_ENTRIES;
        part = quad[0] ? (SINE_TABLE_ENTRIES - rem) : rem;
        x = (part * HALF_PI_Q28) / SINE_TABLE_ENTRIES;
        x2 = (x * x) >> 28;
        term = x;
        sum = longint'(x);
        term = ((term * x2) >> 28) / 6;
        sum = sum - longint'(term);
        term = ((term * x2) >> 28) / 20;
        sum = sum + longint'(term);
        term = ((term * x2) >> 28) / 42;
        sum = sum - longint'(term);
        term = ((term * x2) >> 28) / 72;
        sum = sum + longint'(term);
        term = ((term * x2) >> 28) / 110;
        sum = sum - longint'(term);
        term = ((term * x2) >> 28) / 156;
        sum = sum + longint'(term);
        term = ((term * x2) >> 28) / 210;
        sum = sum - longint'(term);
        if (sum < 0) sum = 0;
        s = (sum + 4096) >>> 13;
        if (s > 32767) s = 32767;
        if (quad >= 2) s = -s;
        return 16'(s);
    endfunction

    q15_t rom [SINE_TABLE_ENTRIES];

    for (genvar k = 0; k < SINE_TABLE_ENTRIES; k++) begin : g_rom
        assign rom[k] = table_entry(k);
    end

    logic [15:0] ang [ANGLES];
    q15_t        e0_reg [ANGLES];
    q15_t        e1_reg [ANGLES];
    logic [15:0] frac_reg [ANGLES];
    q15_t        res_reg [ANGLES];
    logic        v1_reg, v2_reg;

    always_comb begin
        ang[0] = angle;
        ang[2] = angle - THIRD_TURN;
        ang[4] = angle + THIRD_TURN;
        ang[1] = ang[0] + QUARTER_TURN;
        ang[3] = ang[2] + QUARTER_TURN;
        ang[5] = ang[4] + QUARTER_TURN;
    end

    for (genvar j = 0; j < ANGLES; j++) begin : g_angle
        logic [PW-1:0]    p_next;
        logic [IDX_W-1:0] idx_next, nidx_next;
        logic signed [16:0] diff;
        logic signed [33:0] prod;
        logic signed [33:0] step;

        always_comb begin
            p_next = PW'(ang[j]) * PW'(SINE_TABLE_ENTRIES);
            idx_next = p_next[PW-1:16];
            nidx_next = (idx_next == IDX_W'(SINE_TABLE_ENTRIES - 1)) ? '0 : idx_next + 1'b1;
            diff = 17'(e1_reg[j]) - 17'(e0_reg[j]);
            prod = 34'(diff) * $signed({18'd0, frac_reg[j]});
            step = (prod + 34'sd32768) >>> 16;
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                e0_reg[j] <= rom[idx_next];
                e1_reg[j] <= rom[nidx_next];
                frac_reg[j] <= p_next[15:0];
                res_reg[j] <= e0_reg[j] + step[15:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= valid_in;
            v2_reg <= v1_reg;
        end
    end

    assign valid_out = v2_reg;
    for (genvar l = 0; l < LANES; l++) begin : g_out
        assign sin_out[l] = res_reg[2*l];
        assign cos_out[l] = res_reg[2*l+1];
    end
endmodule

// File: rtl/tpwm_divider.sv
module tpwm_divider (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic                        valid_in,
    input  logic [tpwm_pkg::QUO_W-1:0]  dividend [3],
    input  logic                        neg_in [3],
    input  logic [tpwm_pkg::DIV_W-1:0]  divisor,
    output logic                        valid_out,
    output logic [tpwm_pkg::QUO_W-1:0]  quotient [3],
    output logic                        neg_out [3]
);
    import tpwm_pkg::*;

    logic [DIV_W-1:0] rem_reg [QUO_W][LANES];
    logic [QUO_W-1:0] work_reg [QUO_W][LANES];
    logic             neg_reg [QUO_W][LANES];
    logic [DIV_W-1:0] dvs_reg [QUO_W];
    logic [QUO_W-1:0] valid_reg;

    for (genvar i = 0; i < QUO_W; i++) begin : g_stage
        logic [DIV_W-1:0] dvs_in;
        logic             vin;
        if (i == 0) begin : g_first
            assign dvs_in = divisor;
            assign vin = valid_in;
        end else begin : g_rest
            assign dvs_in = dvs_reg[i-1];
            assign vin = valid_reg[i-1];
        end

        for (genvar l = 0; l < LANES; l++) begin : g_lane
            logic [DIV_W-1:0] rem_in;
            logic [QUO_W-1:0] work_in;
            logic             neg_i;
            logic [DIV_W:0]   trial;
            logic             ge;
            logic [DIV_W-1:0] rem_next;
            if (i == 0) begin : g_first
                assign rem_in = '0;
                assign work_in = dividend[l];
                assign neg_i = neg_in[l];
            end else begin : g_rest
                assign rem_in = rem_reg[i-1][l];
                assign work_in = work_reg[i-1][l];
                assign neg_i = neg_reg[i-1][l];
            end

            always_comb begin
                trial = {rem_in, work_in[QUO_W-1]};
                ge = trial >= {1'b0, dvs_in};
                rem_next = ge ? DIV_W'(trial - {1'b0, dvs_in}) : trial[DIV_W-1:0];
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[i][l] <= rem_next;
                    work_reg[i][l] <= {work_in[QUO_W-2:0], ge};
                    neg_reg[i][l] <= neg_i;
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                dvs_reg[i] <= dvs_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[i] <= 1'b0;
            end else if (en) begin
                valid_reg[i] <= vin;
            end
        end
    end

    assign valid_out = valid_reg[QUO_W-1];
    for (genvar l = 0; l < LANES; l++) begin : g_out
        assign quotient[l] = work_reg[QUO_W-1][l];
        assign neg_out[l] = neg_reg[QUO_W-1][l];
    end
endmodule

// File: rtl/three_phase_pwm_duty_generator.sv
// Three-phase PWM duty generator. Each input beat carries an electrical angle, d and q
// voltage references and the bus voltage; each output beat carries the three phase
// compare values. One beat is accepted per clock while s_tready is high, and results
// follow in order; most of the pipeline is the 31-stage restoring divider that scales
// the phase voltages by the bus voltage. A stall on the output freezes the pipeline once
// the output register and its skid stage are both full. Configuration is via APB at
// byte addresses 0x0 (half period), 0x4 (period) and 0x8 (duty scale).
`include "three_phase_pwm_duty_generator_defines.svh"

module three_phase_pwm_duty_generator #(
    parameter int SINE_TABLE_ENTRIES = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // angle, vd_ref, vq_ref, bus_voltage
    input  logic [63:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // duty_a, duty_b, duty_c
    output logic [71:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import tpwm_pkg::*;

    localparam logic [1:0] REG_HALF = 2'd0;
    localparam logic [1:0] REG_PERIOD = 2'd1;
    localparam logic [1:0] REG_SCALE = 2'd2;

    logic [14:0] half_reg;
    logic [15:0] period_reg;
    logic [7:0]  scale_reg;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_reg <= 15'd3375;
            period_reg <= 16'd6750;
            scale_reg <= 8'd1;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                REG_HALF:   half_reg <= pwdata[14:0];
                REG_PERIOD: period_reg <= pwdata[15:0];
                REG_SCALE:  scale_reg <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_HALF:   prdata = {17'd0, half_reg};
            REG_PERIOD: prdata = {16'd0, period_reg};
            REG_SCALE:  prdata = {24'd0, scale_reg};
            default:    prdata = '0;
        endcase
    end

    logic en;
    logic skid_valid_reg;
    assign en = !skid_valid_reg;
    assign s_tready = en;

    // sine and cosine, two stages
    logic sc_valid;
    q15_t sin_v [LANES];
    q15_t cos_v [LANES];

    tpwm_sincos #(
        .SINE_TABLE_ENTRIES(SINE_TABLE_ENTRIES)
    ) u_sincos (
        .aclk(aclk),
        .aresetn(aresetn),
        .en(en),
        .valid_in(s_tvalid),
        .angle(s_tdata[15:0]),
        .valid_out(sc_valid),
        .sin_out(sin_v),
        .cos_out(cos_v)
    );

    q15_t        vd1_reg, vq1_reg, vd2_reg, vq2_reg;
    logic [15:0] vdc1_reg, vdc2_reg, vdc3_reg, vdc4_reg, vdc5_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            vd1_reg <= s_tdata[31:16];
            vq1_reg <= s_tdata[47:32];
            vdc1_reg <= (s_tdata[63:48] == 16'd0) ? 16'd1 : s_tdata[63:48];
            vd2_reg <= vd1_reg;
            vq2_reg <= vq1_reg;
            vdc2_reg <= vdc1_reg;
        end
    end

    // products, sum and magnitude, scale by half period
    logic signed [31:0] psd_reg [LANES];
    logic signed [31:0] pcq_reg [LANES];
    logic [30:0]        mag_reg [LANES];
    logic               neg4_reg [LANES];
    logic               neg5_reg [LANES];
    logic [45:0]        num_reg [LANES];
    logic [QUO_W-1:0]   dividend [LANES];
    logic               v3_reg, v4_reg, v5_reg;

    for (genvar l = 0; l < LANES; l++) begin : g_volt
        logic signed [32:0] v_next;
        logic signed [32:0] a_next;
        always_comb begin
            v_next = 33'(psd_reg[l]) + 33'(pcq_reg[l]);
            a_next = v_next[32] ? -v_next : v_next;
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                psd_reg[l] <= sin_v[l] * vd2_reg;
                pcq_reg[l] <= cos_v[l] * vq2_reg;
                mag_reg[l] <= a_next[30:0];
                neg4_reg[l] <= v_next[32];
                num_reg[l] <= 46'(half_reg) * 46'(mag_reg[l]);
                neg5_reg[l] <= neg4_reg[l];
            end
        end
        assign dividend[l] = num_reg[l][45:15];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            vdc3_reg <= vdc2_reg;
            vdc4_reg <= vdc3_reg;
            vdc5_reg <= vdc4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= sc_valid;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    logic             div_valid;
    logic [QUO_W-1:0] quo [LANES];
    logic             quo_neg [LANES];

    tpwm_divider u_divider (
        .aclk(aclk),
        .aresetn(aresetn),
        .en(en),
        .valid_in(v5_reg),
        .dividend(dividend),
        .neg_in(neg5_reg),
        .divisor(vdc5_reg),
        .valid_out(div_valid),
        .quotient(quo),
        .neg_out(quo_neg)
    );

    // signed times, min-max offset, clamps, scale
    logic signed [35:0] t6_reg [LANES];
    logic signed [35:0] t7_reg [LANES];
    logic signed [35:0] t8_reg [LANES];
    logic signed [35:0] offh_reg [LANES];
    logic [15:0]        d_reg [LANES];
    logic [23:0]        duty_reg [LANES];
    logic signed [35:0] tmax_reg, tmin_reg, offset_reg;
    logic signed [35:0] tmax_next, tmin_next, span, offset_next;
    logic signed [35:0] half_s, per_s;
    logic               v6_reg, v7_reg, v8_reg, v9_reg, v10_reg, v11_reg;

    assign half_s = $signed({21'd0, half_reg});
    assign per_s = $signed({20'd0, period_reg});

    always_comb begin
        tmax_next = t6_reg[0];
        tmin_next = t6_reg[0];
        for (int l = 1; l < LANES; l++) begin
            if (t6_reg[l] > tmax_next) tmax_next = t6_reg[l];
            if (t6_reg[l] < tmin_next) tmin_next = t6_reg[l];
        end
        span = half_s - (tmax_reg - tmin_reg);
        offset_next = ((span + $signed({35'd0, span[35]})) >>> 1) - tmin_reg;
    end

    for (genvar l = 0; l < LANES; l++) begin : g_mod
        logic signed [35:0] on_next, off_next, dd;
        always_comb begin
            on_next = half_s - offh_reg[l];
            if (on_next < 0) on_next = '0;
            if (on_next > per_s) on_next = per_s;
            off_next = offh_reg[l] + half_s;
            if (off_next < half_s) off_next = half_s;
            if (off_next > per_s) off_next = per_s;
            dd = off_next - on_next;
            if (dd < 0) dd = '0;
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                t6_reg[l] <= quo_neg[l] ? -$signed({5'd0, quo[l]}) : $signed({5'd0, quo[l]});
                t7_reg[l] <= t6_reg[l];
                t8_reg[l] <= t7_reg[l];
                offh_reg[l] <= t8_reg[l] + offset_reg;
                d_reg[l] <= dd[15:0];
                duty_reg[l] <= 24'(d_reg[l] * scale_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            tmax_reg <= tmax_next;
            tmin_reg <= tmin_next;
            offset_reg <= offset_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
            v9_reg <= 1'b0;
            v10_reg <= 1'b0;
            v11_reg <= 1'b0;
        end else if (en) begin
            v6_reg <= div_valid;
            v7_reg <= v6_reg;
            v8_reg <= v7_reg;
            v9_reg <= v8_reg;
            v10_reg <= v9_reg;
            v11_reg <= v10_reg;
        end
    end

    // output register with skid stage
    logic [71:0] pipe_data;
    logic        pipe_valid;
    logic        out_valid_reg;
    logic [71:0] out_data_reg, skid_data_reg;

    assign pipe_data = {duty_reg[2], duty_reg[1], duty_reg[0]};
    assign pipe_valid = v11_reg && en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_valid_reg && !m_tready) begin
            if (pipe_valid) skid_valid_reg <= 1'b1;
        end else if (skid_valid_reg) begin
            out_valid_reg <= 1'b1;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= pipe_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_valid_reg && !m_tready) begin
            if (pipe_valid) skid_data_reg <= pipe_data;
        end else if (skid_valid_reg) begin
            out_data_reg <= skid_data_reg;
        end else if (pipe_valid) begin
            out_data_reg <= pipe_data;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = out_data_reg;

    `TPWM_ASSERT_SAME(a_skid_needs_out, skid_valid_reg, out_valid_reg)
    `TPWM_ASSERT_NEXT(a_out_held, out_valid_reg && !m_tready, out_valid_reg)
    `TPWM_ASSERT_NEXT(a_skid_catch, pipe_valid && out_valid_reg && !m_tready, skid_valid_reg)
endmodule
